FILE: rtl/wst_pkg.sv
package wst_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_STOP_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_STATS_INTERVAL = 3'd1;
	localparam logic [2:0] REG_SPEED_INTERVAL = 3'd2;
	localparam logic [2:0] REG_PERIMETER = 3'd3;
	localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
	localparam logic [2:0] REG_UNIT_SELECT = 3'd5;

	// Unit codes
	localparam logic [1:0] UNIT_KMH = 2'd0;
	localparam logic [1:0] UNIT_MS = 2'd1;
	localparam logic [1:0] UNIT_MPH = 2'd2;

	// Multiplier and divisor widths of the shared arithmetic unit
	localparam int MUL_W = 20;
	localparam int EXT_W = 11;
	localparam int QUO_W = 32;
	localparam int QSEL_W = 6;

	// Quotient widths used by the jobs
	localparam logic [QSEL_W-1:0] QB_CMS = 6'd20;
	localparam logic [QSEL_W-1:0] QB_16 = 6'd16;
	localparam logic [QSEL_W-1:0] QB_32 = 6'd32;

	localparam logic [MUL_W-1:0] CMS_SCALE = 20'd100;
	localparam logic [15:0] RPM_SCALE = 16'd60000;
	localparam logic [15:0] OVER_HYST = 16'd20;

	// Jobs run per tick, in this order
	typedef enum logic [2:0] {
		JOB_CMS = 3'd0,
		JOB_RPM = 3'd1,
		JOB_SPD = 3'd2,
		JOB_DST = 3'd3,
		JOB_AVG = 3'd4
	} job_t;

	localparam int NJOB = 5;

	// Speed scale: hundredths of the unit per mm/ms
	function automatic logic [MUL_W-1:0] spd_num(input logic [1:0] u);
		logic [MUL_W-1:0] r;
		unique case (u)
			UNIT_MS:  r = 20'd100;
			UNIT_MPH: r = 20'd312500;
			default:  r = 20'd360;
		endcase
		return r;
	endfunction

	function automatic logic [EXT_W-1:0] spd_den(input logic [1:0] u);
		logic [EXT_W-1:0] r;
		unique case (u)
			UNIT_MPH: r = 11'd1397;
			default:  r = 11'd1;
		endcase
		return r;
	endfunction

	// Distance scale: hundredths of the unit per mm
	function automatic logic [MUL_W-1:0] dst_num(input logic [1:0] u);
		logic [MUL_W-1:0] r;
		unique case (u)
			UNIT_MPH: r = 20'd25;
			default:  r = 20'd1;
		endcase
		return r;
	endfunction

	function automatic logic [18:0] dst_den(input logic [1:0] u);
		logic [18:0] r;
		unique case (u)
			UNIT_MS:  r = 19'd10;
			UNIT_MPH: r = 19'd402336;
			default:  r = 19'd10000;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/wst_muldiv.sv
// Serial floor(a*m/(b*e)) capped at 2^qb-1, 0 if b*e=0: shift-add, restoring division
module wst_muldiv #(
	parameter int AW = 40,
	parameter int BW = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [AW-1:0] a,
	input  logic [wst_pkg::MUL_W-1:0] m,
	input  logic [BW-1:0] b,
	input  logic [wst_pkg::EXT_W-1:0] e,
	input  logic [wst_pkg::QSEL_W-1:0] qb,
	output logic done,
	output logic [wst_pkg::QUO_W-1:0] q
);
	localparam int NW = AW + wst_pkg::MUL_W;
	localparam int DWD = BW + wst_pkg::EXT_W;
	localparam int CW = (NW > DWD) ? NW : DWD;
	localparam int QW = wst_pkg::QUO_W;

	typedef enum logic [4:0] {
		P_IDLE = 5'b00001,
		P_MULN = 5'b00010,
		P_MULD = 5'b00100,
		P_CHK  = 5'b01000,
		P_DIV  = 5'b10000
	} ph_t;

	ph_t ph_q;
	logic done_q;
	logic [NW-1:0] a_sh_q, n_q;
	logic [wst_pkg::MUL_W-1:0] m_sh_q;
	logic [DWD-1:0] b_sh_q, d_q, rem_q;
	logic [wst_pkg::EXT_W-1:0] e_sh_q;
	logic [wst_pkg::QSEL_W-1:0] qb_q, cnt_q;
	logic [QW-1:0] lo_q, q_q;

	logic [CW-1:0] hi_w, d_w;
	logic hi_ge;
	logic [DWD:0] r2;
	logic r2_ge;
	logic [QW-1:0] sat_val;

	// Saturation test and one division step
	always_comb begin
		hi_w = CW'(n_q >> qb_q);
		d_w = CW'(d_q);
		hi_ge = hi_w >= d_w;
		r2 = {rem_q, lo_q[QW-1]};
		r2_ge = r2 >= {1'b0, d_q};
		sat_val = (QW'(1) << qb_q) - QW'(1);
	end

	// Phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			done_q <= 1'b0;
		end else begin
			// Pulse done when a job ends, registered together with its final quotient
			done_q <= (ph_q == P_CHK && (d_q == '0 || hi_ge)) ||
				(ph_q == P_DIV && cnt_q == wst_pkg::QSEL_W'(1));
			unique case (ph_q)
				P_IDLE: if (start) ph_q <= P_MULN;
				P_MULN: if (m_sh_q == '0) ph_q <= P_MULD;
				P_MULD: if (e_sh_q == '0) ph_q <= P_CHK;
				P_CHK: begin
					if (d_q == '0 || hi_ge) begin
						ph_q <= P_IDLE;
					end else begin
						ph_q <= P_DIV;
					end
				end
				P_DIV: begin
					if (cnt_q == wst_pkg::QSEL_W'(1)) begin
						ph_q <= P_IDLE;
					end
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	// Datapath: one multiplier bit or one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (ph_q)
			P_IDLE: begin
				if (start) begin
					a_sh_q <= NW'(a);
					m_sh_q <= m;
					n_q <= '0;
					b_sh_q <= DWD'(b);
					e_sh_q <= e;
					d_q <= '0;
					qb_q <= qb;
				end
			end
			P_MULN: begin
				if (m_sh_q != '0) begin
					if (m_sh_q[0]) n_q <= n_q + a_sh_q;
					a_sh_q <= a_sh_q << 1;
					m_sh_q <= m_sh_q >> 1;
				end
			end
			P_MULD: begin
				if (e_sh_q != '0) begin
					if (e_sh_q[0]) d_q <= d_q + b_sh_q;
					b_sh_q <= b_sh_q << 1;
					e_sh_q <= e_sh_q >> 1;
				end
			end
			P_CHK: begin
				if (d_q == '0) begin
					q_q <= '0;
				end else if (hi_ge) begin
					q_q <= sat_val;
				end else begin
					rem_q <= DWD'(hi_w);
					lo_q <= QW'(n_q) << (wst_pkg::QSEL_W'(QW) - qb_q);
					cnt_q <= qb_q;
					q_q <= '0;
				end
			end
			P_DIV: begin
				if (r2_ge) rem_q <= DWD'(r2 - {1'b0, d_q});
				else rem_q <= DWD'(r2);
				q_q <= {q_q[QW-2:0], r2_ge};
				lo_q <= lo_q << 1;
				cnt_q <= cnt_q - wst_pkg::QSEL_W'(1);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q = q_q;

endmodule

FILE: rtl/wheel_speed_tachometer_top.sv
// Wheel speed tachometer.
// Input channel s_*: one transfer per 1 ms tick, s_tdata[0] is the Hall sample
// (1 = magnet present). Output channel m_*: exactly one result transfer per tick
// with motion flags, held speed and rpm, live distance, average and trip time.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
// write only while no tick is in progress.
// Processing: the tick state is updated in the accept cycle, then a shared
// serial multiply/divide unit runs up to five jobs (overspeed speed, rpm,
// speed, distance, average). Each job multiplies out its two scale factors
// bit by bit, then forms one quotient bit per cycle (20, 16 or 32 bits); a
// quotient known to saturate skips the bit loop. After the last job the
// sequencer passes through ST_LAUNCH and ST_DONE, loads the output register
// once it is free and returns to ST_IDLE to accept the next tick.
// The result sits in an output register: the next tick is accepted while it
// waits; a stalled receiver holds the block only once a second result is ready.
// Reset: registers take their documented defaults, counters and trip clear,
// the output channel is empty.
module wheel_speed_tachometer_top #(
	parameter int TIME_BITS = 32,
	parameter int DISTANCE_BITS = 40
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,     // [0] magnet, [7:1] zero
	output logic m_tvalid,
	input  logic m_tready,
	// [0] moving, [1] overspeed, [2] started, [3] stopped, [4] speed_update,
	// [20:5] speed, [21] stats_update, [37:22] rpm, [69:38] distance,
	// [85:70] average_speed, [86] trip_update, [118:87] trip_time_ms, [119] zero
	output logic [119:0] m_tdata,
	input  logic cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [15:0] cfg_wdata
);
	localparam int TW = TIME_BITS;
	localparam int DW = DISTANCE_BITS;
	localparam int BW = (TW > 19) ? TW : 19;
	localparam logic [TW-1:0] TMAX = '1;
	localparam logic [DW-1:0] DMAX = '1;
	localparam int NJOB_W = wst_pkg::NJOB;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LAUNCH = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_DONE   = 4'b1000
	} st_t;

	st_t st_q;

	// Configuration
	logic [15:0] timeout_q, stats_int_q, speed_int_q, limit_q;
	logic [12:0] perim_q;
	logic [1:0] unit_q;

	// Tick state
	logic seen_q, gap_q, armed_q, run_q, mov_q, over_q;
	logic [15:0] lvl_q;
	logic [TW-1:0] per_q, trip_q, tdiv_q, last_q, mt_q, sel_q, spel_q;
	logic [6:0] tmod_q;
	logic [DW-1:0] dist_q;
	logic [15:0] hspd_q, hrpm_q, td_q, avg_q;
	logic [31:0] dout_q;
	logic started_q, stopped_q, spdup_q, stup_q, tripup_q;
	logic [NJOB_W-1:0] pend_q;
	wst_pkg::job_t job_q;
	logic m_tvalid_q;
	logic [119:0] m_tdata_q;
	logic out_load;

	// Next-state values for the accept cycle
	logic n_seen, n_gap, n_armed, n_run, n_mov, n_over;
	logic [15:0] n_lvl, n_hspd, n_hrpm, n_td;
	logic [TW-1:0] n_per, n_trip, n_tdiv, n_last, n_mt, n_sel, n_spel;
	logic [6:0] n_tmod;
	logic [DW-1:0] n_dist;
	logic n_started, n_stopped, n_spdup, n_stup, n_tripup;
	logic [NJOB_W-1:0] n_pend;
	logic do_lvl, lvl_gap, lvl_flag;
	logic [TW-1:0] t_per;
	logic [TW:0] s_mt, s_sel, s_spel;
	logic [DW:0] s_dist;

	always_comb begin
		n_seen = seen_q;
		n_gap = gap_q;
		n_armed = armed_q;
		n_run = run_q;
		n_mov = mov_q;
		n_over = over_q;
		n_hspd = hspd_q;
		n_hrpm = hrpm_q;
		n_td = td_q;
		n_mt = mt_q;
		n_sel = sel_q;
		n_spel = spel_q;
		n_dist = dist_q;
		n_started = 1'b0;
		n_stopped = 1'b0;
		n_spdup = 1'b0;
		n_stup = 1'b0;
		n_tripup = 1'b0;
		n_pend = '0;
		do_lvl = 1'b0;
		lvl_gap = 1'b0;
		lvl_flag = 1'b0;
		t_per = '0;
		s_mt = '0;
		s_sel = '0;
		s_spel = '0;
		s_dist = '0;

		// Advance the timers
		n_per = (seen_q && per_q != TMAX) ? per_q + TW'(1) : per_q;
		n_lvl = (lvl_q != 16'hFFFF) ? lvl_q + 16'd1 : lvl_q;
		n_trip = trip_q;
		n_tdiv = tdiv_q;
		n_tmod = tmod_q;
		if (run_q && trip_q != TMAX) begin
			n_trip = trip_q + TW'(1);
			if (tmod_q == 7'd99) begin
				n_tmod = '0;
				n_tdiv = tdiv_q + TW'(1);
			end else begin
				n_tmod = tmod_q + 7'd1;
			end
		end

		// Flag a new 100 ms step of the trip
		n_last = last_q;
		if (mov_q && n_tdiv != last_q) begin
			n_last = n_tdiv;
			n_tripup = 1'b1;
		end

		if (s_tdata[0]) begin
			if (!seen_q) begin
				n_seen = 1'b1;
				n_gap = 1'b0;
				n_armed = 1'b0;
				n_per = '0;
				n_trip = '0;
				n_tdiv = '0;
				n_tmod = '0;
				n_run = 1'b1;
			end else begin
				do_lvl = 1'b1;
				if (gap_q) begin
					t_per = n_per;
					n_gap = 1'b0;
					n_armed = 1'b0;
					n_per = '0;
					if (t_per > TW'(timeout_q)) begin
						// Long period: restart measurement only
						n_run = 1'b1;
						do_lvl = 1'b0;
					end else begin
						n_td = (t_per == '0) ? 16'd1 : t_per[15:0];
						if (!mov_q) begin
							n_mov = 1'b1;
							n_run = 1'b1;
							n_started = 1'b1;
						end
						s_mt = {1'b0, mt_q} + {1'b0, t_per};
						s_sel = {1'b0, sel_q} + {1'b0, t_per};
						s_spel = {1'b0, spel_q} + {1'b0, t_per};
						s_dist = {1'b0, dist_q} + (DW+1)'(perim_q);
						n_mt = s_mt[TW] ? TMAX : s_mt[TW-1:0];
						n_sel = s_sel[TW] ? TMAX : s_sel[TW-1:0];
						n_spel = s_spel[TW] ? TMAX : s_spel[TW-1:0];
						n_dist = s_dist[DW] ? DMAX : s_dist[DW-1:0];
						n_pend[wst_pkg::JOB_CMS] = 1'b1;
						if (n_sel > TW'(stats_int_q)) begin
							n_sel = '0;
							n_stup = 1'b1;
							n_pend[wst_pkg::JOB_RPM] = 1'b1;
						end
						if (n_spel > TW'(speed_int_q)) begin
							n_spel = '0;
							n_spdup = 1'b1;
							n_pend[wst_pkg::JOB_SPD] = 1'b1;
						end
					end
				end
			end
		end else begin
			do_lvl = 1'b1;
			lvl_gap = 1'b1;
		end

		// Level hold check: arm on first sample of a level, stop on timeout
		if (do_lvl) begin
			lvl_flag = lvl_gap ? n_gap : n_armed;
			if (!lvl_flag) begin
				if (lvl_gap) n_gap = 1'b1;
				else n_armed = 1'b1;
				n_lvl = '0;
			end
			if (n_mov && n_lvl > timeout_q) begin
				n_mov = 1'b0;
				n_over = 1'b0;
				n_run = 1'b0;
				n_hspd = '0;
				n_hrpm = '0;
				n_stopped = 1'b1;
			end
		end

		n_pend[wst_pkg::JOB_DST] = 1'b1;
		n_pend[wst_pkg::JOB_AVG] = (n_mt != '0);
	end

	// Job selection and operands of the serial unit
	wst_pkg::job_t job_sel;
	logic u_start, u_done;
	logic [DW-1:0] u_a;
	logic [wst_pkg::MUL_W-1:0] u_m;
	logic [BW-1:0] u_b;
	logic [wst_pkg::EXT_W-1:0] u_e;
	logic [wst_pkg::QSEL_W-1:0] u_qb;
	logic [wst_pkg::QUO_W-1:0] u_q;

	always_comb begin
		priority if (pend_q[wst_pkg::JOB_CMS]) job_sel = wst_pkg::JOB_CMS;
		else if (pend_q[wst_pkg::JOB_RPM]) job_sel = wst_pkg::JOB_RPM;
		else if (pend_q[wst_pkg::JOB_SPD]) job_sel = wst_pkg::JOB_SPD;
		else if (pend_q[wst_pkg::JOB_DST]) job_sel = wst_pkg::JOB_DST;
		else job_sel = wst_pkg::JOB_AVG;

		u_start = (st_q == ST_LAUNCH) && (pend_q != '0);

		unique case (job_sel)
			wst_pkg::JOB_CMS: begin
				u_a = DW'(perim_q);
				u_m = wst_pkg::CMS_SCALE;
				u_b = BW'(td_q);
				u_e = wst_pkg::EXT_W'(1);
				u_qb = wst_pkg::QB_CMS;
			end
			wst_pkg::JOB_RPM: begin
				u_a = DW'(wst_pkg::RPM_SCALE);
				u_m = wst_pkg::MUL_W'(1);
				u_b = BW'(td_q);
				u_e = wst_pkg::EXT_W'(1);
				u_qb = wst_pkg::QB_16;
			end
			wst_pkg::JOB_SPD: begin
				u_a = DW'(perim_q);
				u_m = wst_pkg::spd_num(unit_q);
				u_b = BW'(td_q);
				u_e = wst_pkg::spd_den(unit_q);
				u_qb = wst_pkg::QB_16;
			end
			wst_pkg::JOB_DST: begin
				u_a = dist_q;
				u_m = wst_pkg::dst_num(unit_q);
				u_b = BW'(wst_pkg::dst_den(unit_q));
				u_e = wst_pkg::EXT_W'(1);
				u_qb = wst_pkg::QB_32;
			end
			default: begin
				u_a = dist_q;
				u_m = wst_pkg::spd_num(unit_q);
				u_b = BW'(mt_q);
				u_e = wst_pkg::spd_den(unit_q);
				u_qb = wst_pkg::QB_16;
			end
		endcase
	end

	wst_muldiv #(
		.AW(DW),
		.BW(BW)
	) u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(u_start),
		.a(u_a),
		.m(u_m),
		.b(u_b),
		.e(u_e),
		.qb(u_qb),
		.done(u_done),
		.q(u_q)
	);

	// Overspeed with hysteresis from the fresh cm/s figure
	logic [19:0] cms;
	logic ov_set, ov_next;

	always_comb begin
		cms = u_q[19:0];
		ov_set = over_q || (cms >= 20'(limit_q));
		ov_next = ov_set;
		if (ov_set && limit_q >= wst_pkg::OVER_HYST && cms < 20'(limit_q - wst_pkg::OVER_HYST))
			ov_next = 1'b0;
	end

	// Trip time saturated to 32 bits
	logic [63:0] trip_w;
	logic [31:0] trip_out;

	always_comb begin
		trip_w = 64'(trip_q);
		trip_out = (trip_w[63:32] != '0) ? 32'hFFFF_FFFF : trip_w[31:0];
	end

	// Load the output register once the result is ready and the register is free
	assign out_load = (st_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// Sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			timeout_q <= 16'd1500;
			stats_int_q <= 16'd500;
			speed_int_q <= 16'd150;
			perim_q <= 13'd2073;
			limit_q <= 16'd1666;
			unit_q <= wst_pkg::UNIT_KMH;
			seen_q <= 1'b0;
			gap_q <= 1'b0;
			armed_q <= 1'b0;
			run_q <= 1'b0;
			mov_q <= 1'b0;
			over_q <= 1'b0;
			lvl_q <= '0;
			per_q <= '0;
			trip_q <= '0;
			tdiv_q <= '0;
			tmod_q <= '0;
			last_q <= '1;
			mt_q <= '0;
			sel_q <= '0;
			spel_q <= '0;
			dist_q <= '0;
			hspd_q <= '0;
			hrpm_q <= '0;
			td_q <= '0;
			avg_q <= '0;
			dout_q <= '0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
			spdup_q <= 1'b0;
			stup_q <= 1'b0;
			tripup_q <= 1'b0;
			pend_q <= '0;
			job_q <= wst_pkg::JOB_CMS;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			// Configuration writes
			if (cfg_we) begin
				unique case (cfg_addr)
					wst_pkg::REG_STOP_TIMEOUT:   timeout_q <= cfg_wdata;
					wst_pkg::REG_STATS_INTERVAL: stats_int_q <= cfg_wdata;
					wst_pkg::REG_SPEED_INTERVAL: speed_int_q <= cfg_wdata;
					wst_pkg::REG_PERIMETER:      perim_q <= cfg_wdata[12:0];
					wst_pkg::REG_SPEED_LIMIT:    limit_q <= cfg_wdata;
					wst_pkg::REG_UNIT_SELECT:    unit_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end

			// Raise valid on a new result, drop it once transferred
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						seen_q <= n_seen;
						gap_q <= n_gap;
						armed_q <= n_armed;
						run_q <= n_run;
						mov_q <= n_mov;
						over_q <= n_over;
						lvl_q <= n_lvl;
						per_q <= n_per;
						trip_q <= n_trip;
						tdiv_q <= n_tdiv;
						tmod_q <= n_tmod;
						last_q <= n_last;
						mt_q <= n_mt;
						sel_q <= n_sel;
						spel_q <= n_spel;
						dist_q <= n_dist;
						hspd_q <= n_hspd;
						hrpm_q <= n_hrpm;
						td_q <= n_td;
						started_q <= n_started;
						stopped_q <= n_stopped;
						spdup_q <= n_spdup;
						stup_q <= n_stup;
						tripup_q <= n_tripup;
						pend_q <= n_pend;
						if (n_mt == '0) avg_q <= '0;
						st_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					if (pend_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						job_q <= job_sel;
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (u_done) begin
						unique case (job_q)
							wst_pkg::JOB_CMS: over_q <= ov_next;
							wst_pkg::JOB_RPM: hrpm_q <= u_q[15:0];
							wst_pkg::JOB_SPD: hspd_q <= u_q[15:0];
							wst_pkg::JOB_DST: dout_q <= u_q;
							default:          avg_q <= u_q[15:0];
						endcase
						pend_q[job_q] <= 1'b0;
						st_q <= ST_LAUNCH;
					end
				end
				ST_DONE: begin
					// Hand the result to the output register once it is free
					if (out_load) begin
						m_tdata_q <= {1'b0, trip_out, tripup_q, avg_q, dout_q, hrpm_q, stup_q,
							hspd_q, spdup_q, stopped_q, started_q, over_q, mov_q};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

FILE: bench/tb_wheel_speed_tachometer_top.sv
`timescale 1ns / 1ps

module tb_wheel_speed_tachometer_top;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [31:0] trip_time_ms;
		logic        trip_update;
		logic [15:0] average_speed;
		logic [31:0] distance;
		logic [15:0] rpm;
		logic        stats_update;
		logic [15:0] speed;
		logic        speed_update;
		logic        stopped;
		logic        started;
		logic        overspeed;
		logic        moving;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;

	// Predictor copy of configuration
	logic [15:0] p_stop, p_stats_int, p_speed_int, p_limit;
	logic [12:0] p_perim;
	logic [1:0] p_unit;
	// Predictor copy of state
	bit p_seen_first, p_gap_seen, p_present_armed, p_trip_running, p_moving, p_over;
	int unsigned p_level;
	longint unsigned p_period, p_trip, p_last_step, p_dist_mm;
	longint unsigned p_move_time, p_stats_el, p_speed_el;
	logic [15:0] p_held_speed, p_held_rpm;

	tick_result_t expected_ticks[$];
	int errors = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	bit long_hold = 1'b0;
	bit stall_enable = 1'b1;

	wheel_speed_tachometer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
			longint unsigned cap);
		if (b >= cap || a >= cap - b) return cap;
		return a + b;
	endfunction

	// floor(a*m/d) saturated to cap, with 128-bit intermediate
	function automatic longint unsigned scale_sat(longint unsigned a, longint unsigned m,
			longint unsigned d, longint unsigned cap);
		logic [127:0] prod;
		if (d == 0 || m == 0) return 0;
		prod = (128'(a) * 128'(m)) / 128'(d);
		if (prod > 128'(cap)) return cap;
		return prod[63:0];
	endfunction

	function automatic longint unsigned spd_scale_num(logic [1:0] u);
		case (u)
			wst_pkg::UNIT_MS:  return 100;
			wst_pkg::UNIT_MPH: return 312500;
			default:           return 360;
		endcase
	endfunction

	function automatic longint unsigned spd_scale_den(logic [1:0] u);
		return (u == wst_pkg::UNIT_MPH) ? 1397 : 1;
	endfunction

	function automatic bit check_level_hold(ref bit armed);
		if (!armed) begin
			armed = 1'b1;
			p_level = 0;
		end
		if (p_moving && p_level > p_stop) begin
			p_moving = 1'b0;
			p_over = 1'b0;
			p_trip_running = 1'b0;
			p_held_speed = '0;
			p_held_rpm = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic reset_predictor();
		p_stop = 1500; p_stats_int = 500; p_speed_int = 150;
		p_perim = 2073; p_limit = 1666; p_unit = wst_pkg::UNIT_KMH;
		p_seen_first = 0; p_gap_seen = 0; p_present_armed = 0;
		p_trip_running = 0; p_moving = 0; p_over = 0;
		p_level = 0; p_period = 0; p_trip = 0; p_last_step = '1;
		p_dist_mm = 0; p_move_time = 0; p_stats_el = 0; p_speed_el = 0;
		p_held_speed = 0; p_held_rpm = 0;
	endtask

	// Advance the predictor by one tick and queue its result
	task automatic predict_tick(bit magnet);
		tick_result_t r;
		bit checked;
		longint unsigned t, td, cms, step, dmax, tmax, dden;
		r = '0;
		tmax = 64'hFFFF_FFFF;
		dmax = 64'hFF_FFFF_FFFF;
		if (p_seen_first) p_period = sat_sum(p_period, 1, tmax);
		if (p_level < 65535) p_level++;
		if (p_trip_running) p_trip = sat_sum(p_trip, 1, tmax);
		if (p_moving) begin
			step = p_trip / 100;
			if (step != p_last_step) begin
				p_last_step = step;
				r.trip_update = 1'b1;
			end
		end
		if (magnet) begin
			if (!p_seen_first) begin
				p_seen_first = 1; p_gap_seen = 0; p_present_armed = 0;
				p_period = 0; p_trip = 0; p_trip_running = 1;
			end else begin
				checked = 1'b1;
				if (p_gap_seen) begin
					t = p_period;
					p_gap_seen = 0; p_present_armed = 0; p_period = 0;
					if (t > p_stop) begin
						p_trip_running = 1;
						checked = 1'b0;
					end else begin
						td = (t != 0) ? t : 1;
						cms = longint'(p_perim) * 100 / td;
						if (!p_moving) begin
							p_moving = 1; p_trip_running = 1; r.started = 1'b1;
						end
						p_move_time = sat_sum(p_move_time, t, tmax);
						p_stats_el = sat_sum(p_stats_el, t, tmax);
						p_speed_el = sat_sum(p_speed_el, t, tmax);
						p_dist_mm = sat_sum(p_dist_mm, p_perim, dmax);
						if (!p_over && cms >= p_limit) p_over = 1;
						if (p_over && p_limit >= 20 && cms < longint'(p_limit) - 20) p_over = 0;
						if (p_stats_el > p_stats_int) begin
							p_stats_el = 0;
							p_held_rpm = 16'(60000 / td);
							r.stats_update = 1'b1;
						end
						if (p_speed_el > p_speed_int) begin
							p_speed_el = 0;
							p_held_speed = 16'(scale_sat(p_perim, spd_scale_num(p_unit),
								spd_scale_den(p_unit) * td, 65535));
							r.speed_update = 1'b1;
						end
					end
				end
				if (checked) r.stopped = check_level_hold(p_present_armed);
			end
		end else begin
			r.stopped = check_level_hold(p_gap_seen);
		end
		if (p_move_time != 0)
			r.average_speed = 16'(scale_sat(p_dist_mm, spd_scale_num(p_unit),
				spd_scale_den(p_unit) * p_move_time, 65535));
		dden = (p_unit == wst_pkg::UNIT_MS) ? 10 : (p_unit == wst_pkg::UNIT_MPH) ? 402336 : 10000;
		r.distance = 32'(scale_sat(p_dist_mm, (p_unit == wst_pkg::UNIT_MPH) ? 25 : 1, dden,
			tmax));
		r.moving = p_moving;
		r.overspeed = p_over;
		r.speed = p_held_speed;
		r.rpm = p_held_rpm;
		r.trip_time_ms = 32'(p_trip);
		expected_ticks = {expected_ticks, r};
	endtask

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		errors++;
		$display("mismatch result %0d %s: got %0d expected %0d", results_seen, what, got, want);
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		tick_result_t g, e;
		if (arst_n && m_tvalid && m_tready) begin
			g = tick_result_t'(m_tdata[118:0]);
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected", 0, 0);
			end else begin
				e = expected_ticks.pop_front();
				if (g.moving != e.moving) report_mismatch("moving", g.moving, e.moving);
				if (g.overspeed != e.overspeed)
					report_mismatch("overspeed", g.overspeed, e.overspeed);
				if (g.started != e.started) report_mismatch("started", g.started, e.started);
				if (g.stopped != e.stopped) report_mismatch("stopped", g.stopped, e.stopped);
				if (g.speed_update != e.speed_update)
					report_mismatch("speed_update", g.speed_update, e.speed_update);
				if (g.speed != e.speed) report_mismatch("speed", g.speed, e.speed);
				if (g.stats_update != e.stats_update)
					report_mismatch("stats_update", g.stats_update, e.stats_update);
				if (g.rpm != e.rpm) report_mismatch("rpm", g.rpm, e.rpm);
				if (g.distance != e.distance) report_mismatch("distance", g.distance, e.distance);
				if (g.average_speed != e.average_speed)
					report_mismatch("average_speed", g.average_speed, e.average_speed);
				if (g.trip_update != e.trip_update)
					report_mismatch("trip_update", g.trip_update, e.trip_update);
				if (g.trip_time_ms != e.trip_time_ms)
					report_mismatch("trip_time_ms", g.trip_time_ms, e.trip_time_ms);
			end
			results_seen++;
		end
	end

	// Receiver stall pattern, with an occasional long hold-off
	always @(posedge clk) begin
		if (long_hold) m_tready <= 1'b0;
		else if (!stall_enable) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || long_hold)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	int burst_left = 0;

	// Send one tick; bursts of random length separated by random gaps
	task automatic send_tick(bit magnet);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, magnet};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tick(magnet);
		// Drop valid at the end of a burst
		if (burst_left == 0) s_tvalid <= 1'b0;
	endtask

	// Close an unfinished burst so the input goes idle
	task automatic end_burst();
		if (burst_left != 0) begin
			burst_left = 0;
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic drain();
		end_burst();
		@(posedge clk);
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wst_pkg::REG_STOP_TIMEOUT:   p_stop = val;
			wst_pkg::REG_STATS_INTERVAL: p_stats_int = val;
			wst_pkg::REG_SPEED_INTERVAL: p_speed_int = val;
			wst_pkg::REG_PERIMETER:      p_perim = val[12:0];
			wst_pkg::REG_SPEED_LIMIT:    p_limit = val;
			wst_pkg::REG_UNIT_SELECT:    p_unit = val[1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int stop, int st, int sp, int per, int lim, int unit);
		drain();
		write_reg(wst_pkg::REG_STOP_TIMEOUT, 16'(stop));
		write_reg(wst_pkg::REG_STATS_INTERVAL, 16'(st));
		write_reg(wst_pkg::REG_SPEED_INTERVAL, 16'(sp));
		write_reg(wst_pkg::REG_PERIMETER, 16'(per));
		write_reg(wst_pkg::REG_SPEED_LIMIT, 16'(lim));
		write_reg(wst_pkg::REG_UNIT_SELECT, 16'(unit));
	endtask

	// One revolution: magnet present for hi ticks, absent for lo ticks
	task automatic send_rev(int hi, int lo);
		repeat (hi) send_tick(1'b1);
		repeat (lo) send_tick(1'b0);
	endtask

	// Directed: first magnet, a revolution with a zero-length gap, stop by held level
	task automatic test_directed();
		set_config(8, 1, 1, 8191, 0, wst_pkg::UNIT_KMH);
		send_rev(1, 1);
		send_rev(1, 1);
		send_rev(2, 1);
		send_rev(1, 2);
		send_rev(1, 12);
		send_rev(1, 1);
		send_rev(1, 0);
		repeat (3) send_tick(1'b1);
	endtask

	// Rides with trains of regular revolutions and some noise
	task automatic test_rides(int n_items, int max_lo);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			int hi, lo;
			if ($urandom_range(0, 9) == 0) begin
				send_tick($urandom_range(0, 1));
				sent++;
			end else begin
				hi = $urandom_range(1, 3);
				lo = $urandom_range(1, max_lo);
				send_rev(hi, lo);
				sent += hi + lo;
			end
		end
	endtask

	// Hold the receiver off so the block fills and stalls its input
	task automatic test_backpressure();
		fork
			begin
				long_hold = 1'b1;
				repeat (800) @(posedge clk);
				long_hold = 1'b0;
			end
			test_rides(40, 6);
		join
	endtask

	initial begin
		reset_predictor();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_config(20, 30, 10, 2073, 1666, wst_pkg::UNIT_KMH);
		test_rides(250, 10);
		set_config(65535, 65535, 65535, 1, 65535, wst_pkg::UNIT_MS);
		test_rides(150, 15);
		set_config(12, 5, 3, 8191, 19, wst_pkg::UNIT_MPH);
		test_rides(250, 8);
		set_config(25, 40, 20, 4000, 3000, 3);
		test_backpressure();
		stall_enable = 1'b0;
		test_rides(200, 12);
		stall_enable = 1'b1;
		set_config(1, 2, 1, 1500, 20, wst_pkg::UNIT_KMH);
		test_rides(150, 3);
		set_config(30, 17, 9, 5000, 40000, wst_pkg::UNIT_MS);
		test_rides(250, 20);
		drain();
		$display("covered %0d tick results over seven register settings, all units,", results_seen);
		$display("stops, overspeed hysteresis and a long receiver hold-off");
		if (errors == 0 && expected_ticks.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
